@@ rtl/llq_pkg.sv @@
// types and codes shared by the linked list queue manager
package llq_pkg;

  // one input beat
  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  list_id;
    logic [5:0]  entry;
    logic [31:0] channel;
    logic [2:0]  cpu;
  } llq_in_t;

  // one result beat
  typedef struct packed {
    logic [5:0] popped_entry;
    logic [6:0] tally;
    logic [1:0] status;
  } llq_out_t;

  // operation codes
  localparam logic [2:0] MODE_POP    = 3'd0;
  localparam logic [2:0] MODE_APPEND = 3'd1;
  localparam logic [2:0] MODE_REMOVE = 3'd2;
  localparam logic [2:0] MODE_SLEEP  = 3'd3;
  localparam logic [2:0] MODE_WAKE   = 3'd4;
  localparam logic [2:0] MODE_COUNT  = 3'd5;
  localparam logic [2:0] MODE_SETAFF = 3'd6;

  // status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_EMPTY    = 2'd1;
  localparam logic [1:0] STAT_LINKED   = 2'd2;
  localparam logic [1:0] STAT_NOTFOUND = 2'd3;

  // fixed list numbers
  localparam int LIST_FREE  = 0;
  localparam int LIST_SLEEP = 1;
  localparam int LIST_RUN0  = 3;

  localparam logic [6:0] TALLY_MAX = 7'd127;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_START,
    ST_POP2,
    ST_CHECK,
    ST_WALK_RD,
    ST_WALK,
    ST_FIX,
    ST_DONE
  } state_e;

endpackage

@@ rtl/llq_ram.sv @@
// generic single write, single read ram with registered read data
module llq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/llq_heads.sv @@
// list head register file, free list holds entry 0 after reset
module llq_heads #(
  parameter int NUM_LISTS   = 11,
  parameter int NUM_ENTRIES = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [$clog2(NUM_LISTS)-1:0]         raddr_i,
  output logic [$clog2(NUM_ENTRIES+2)-1:0]     rdata_o,
  input  logic                                 we_i,
  input  logic [$clog2(NUM_LISTS)-1:0]         waddr_i,
  input  logic [$clog2(NUM_ENTRIES+2)-1:0]     wdata_i
);
  import llq_pkg::*;

  localparam int LW = $clog2(NUM_ENTRIES + 2);
  localparam logic [LW-1:0] END_L = LW'(NUM_ENTRIES);

  logic [LW-1:0] heads_q [NUM_LISTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        heads_q[i] <= (i == LIST_FREE) ? '0 : END_L;
      end
    end else if (we_i) begin
      heads_q[waddr_i] <= wdata_i;
    end
  end

  // list numbers past the last run list read as empty
  assign rdata_o = (32'(raddr_i) < NUM_LISTS) ? heads_q[raddr_i] : END_L;

endmodule

@@ rtl/linked_list_queue_manager.sv @@
// top level: sequencer that walks the shared link table one link per cycle
//
//   port group  dir  handshake                   payload
//   in          in   in_valid_i / in_ready_o     llq_in_t in_i
//   out         out  out_valid_o / out_ready_i   llq_out_t out_o
//
// after reset the link table and affinities are swept, every entry in turn, before in_ready_o.
// append, remove and count walk the list; wake walks the sleep list and moves each matching
// entry to its run list. the link ram read port sets the pace: one link a cycle.
// one item is in work at a time; a finished result waits in the output register and the
// sequencer holds its done state while that register is still full.
module linked_list_queue_manager #(
  parameter int NUM_ENTRIES  = 64,
  parameter int NUM_CPUS     = 8,
  parameter int CHANNEL_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  llq_pkg::llq_in_t   in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output llq_pkg::llq_out_t  out_o
);
  import llq_pkg::*;

  localparam int NUM_LISTS = 3 + NUM_CPUS;
  localparam int IW = $clog2(NUM_ENTRIES);
  localparam int LW = $clog2(NUM_ENTRIES + 2);
  localparam int HW = $clog2(NUM_LISTS);
  localparam int CW = $clog2(NUM_ENTRIES + 2);
  localparam logic [LW-1:0] END_L  = LW'(NUM_ENTRIES);
  localparam logic [LW-1:0] NONE_L = LW'(NUM_ENTRIES + 1);
  localparam logic [CW-1:0] N_C    = CW'(NUM_ENTRIES);
  localparam logic [IW-1:0] LAST_I = IW'(NUM_ENTRIES - 1);
  localparam logic [HW-1:0] SLEEP_H = HW'(LIST_SLEEP);

  state_e state_q, state_d;

  logic [IW-1:0]           init_q, init_d;
  logic [2:0]              mode_q, mode_d;
  logic [3:0]              lst_q, lst_d;
  logic [5:0]              e_q, e_d;
  logic [CHANNEL_BITS-1:0] ch_q, ch_d;
  logic [2:0]              cpu_q, cpu_d;
  logic [LW-1:0]           cur_q, cur_d;
  logic [LW-1:0]           nxt_q, nxt_d;
  logic [IW-1:0]           prev_q, prev_d;
  logic                    at_head_q, at_head_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [6:0]              woken_q, woken_d;
  logic [1:0]              status_q, status_d;
  logic [HW-1:0]           run_q, run_d;
  logic                    out_valid_q, out_valid_d;
  llq_out_t                out_q, out_d;

  // memory ports
  logic                    nl_we;
  logic [IW-1:0]           nl_waddr, nl_raddr;
  logic [LW-1:0]           nl_wdata, nl_rdata;
  logic                    wc_we;
  logic [CHANNEL_BITS-1:0] wc_rdata;
  logic                    aff_we;
  logic [IW-1:0]           aff_waddr;
  logic [2:0]              aff_wdata, aff_rdata;
  logic                    hd_we;
  logic [HW-1:0]           hd_waddr, hd_raddr;
  logic [LW-1:0]           hd_wdata, hd_rdata;

  // shared conditions
  logic          lst_ok, e_ok, cpu_ok, head_empty, cont, out_load;
  logic [IW-1:0] cur_idx, e_idx, nxt_idx;
  logic [HW-1:0] lst_idx;
  logic [2:0]    aff_cpu;

  assign lst_ok     = 32'(lst_q) < NUM_LISTS;
  assign e_ok       = 32'(e_q) < NUM_ENTRIES;
  assign cpu_ok     = 32'(cpu_q) < NUM_CPUS;
  assign head_empty = hd_rdata >= END_L;
  assign cont       = (nl_rdata < END_L) && (cnt_q < N_C);
  assign cur_idx    = cur_q[IW-1:0];
  assign nxt_idx    = nl_rdata[IW-1:0];
  assign e_idx      = IW'(e_q);
  assign lst_idx    = HW'(lst_q);
  assign aff_cpu    = (32'(aff_rdata) < NUM_CPUS) ? aff_rdata : 3'd0;
  assign out_load   = !out_valid_q || out_ready_i;

  llq_ram #(.WIDTH(LW), .DEPTH(NUM_ENTRIES)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (nl_we),
    .waddr_i (nl_waddr),
    .wdata_i (nl_wdata),
    .raddr_i (nl_raddr),
    .rdata_o (nl_rdata)
  );

  llq_ram #(.WIDTH(CHANNEL_BITS), .DEPTH(NUM_ENTRIES)) u_chan_ram (
    .clk_i   (clk_i),
    .we_i    (wc_we),
    .waddr_i (e_idx),
    .wdata_i (ch_q),
    .raddr_i (nl_raddr),
    .rdata_o (wc_rdata)
  );

  llq_ram #(.WIDTH(3), .DEPTH(NUM_ENTRIES)) u_aff_ram (
    .clk_i   (clk_i),
    .we_i    (aff_we),
    .waddr_i (aff_waddr),
    .wdata_i (aff_wdata),
    .raddr_i (nl_raddr),
    .rdata_o (aff_rdata)
  );

  llq_heads #(.NUM_LISTS(NUM_LISTS), .NUM_ENTRIES(NUM_ENTRIES)) u_heads (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .raddr_i (hd_raddr),
    .rdata_o (hd_rdata),
    .we_i    (hd_we),
    .waddr_i (hd_waddr),
    .wdata_i (hd_wdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (init_q == LAST_I) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_START;
      end
      ST_START: begin
        case (mode_q)
          MODE_POP:    state_d = (!lst_ok || head_empty) ? ST_DONE : ST_POP2;
          MODE_APPEND: state_d = (!lst_ok || !e_ok) ? ST_DONE : ST_CHECK;
          MODE_REMOVE: state_d = (!lst_ok || !e_ok) ? ST_DONE : ST_WALK_RD;
          MODE_SLEEP:  state_d = !e_ok ? ST_DONE : ST_CHECK;
          MODE_WAKE:   state_d = ST_WALK_RD;
          MODE_COUNT:  state_d = lst_ok ? ST_WALK_RD : ST_DONE;
          default:     state_d = ST_DONE;
        endcase
      end
      ST_POP2: state_d = ST_DONE;
      ST_CHECK: begin
        if (nl_rdata != NONE_L || mode_q == MODE_SLEEP || head_empty) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_WALK_RD;
        end
      end
      ST_WALK_RD: begin
        state_d = (cur_q >= END_L || cnt_q > N_C) ? ST_DONE : ST_WALK;
      end
      ST_WALK: begin
        case (mode_q)
          MODE_APPEND: begin
            if (!(nl_rdata < END_L && cnt_q <= N_C)) state_d = ST_DONE;
          end
          MODE_COUNT: begin
            if (!cont) state_d = ST_DONE;
          end
          MODE_REMOVE: begin
            if (cur_q == LW'(e_q)) state_d = ST_FIX;
            else if (!cont) state_d = ST_DONE;
          end
          MODE_WAKE: begin
            if (wc_rdata == ch_q) state_d = ST_FIX;
            else if (!cont) state_d = ST_DONE;
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_FIX: state_d = (mode_q == MODE_WAKE) ? ST_WALK_RD : ST_DONE;
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    init_d      = init_q;
    mode_d      = mode_q;
    lst_d       = lst_q;
    e_d         = e_q;
    ch_d        = ch_q;
    cpu_d       = cpu_q;
    cur_d       = cur_q;
    nxt_d       = nxt_q;
    prev_d      = prev_q;
    at_head_d   = at_head_q;
    cnt_d       = cnt_q;
    woken_d     = woken_q;
    status_d    = status_q;
    run_d       = run_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    nl_we       = 1'b0;
    nl_waddr    = cur_idx;
    nl_wdata    = NONE_L;
    nl_raddr    = cur_idx;
    wc_we       = 1'b0;
    aff_we      = 1'b0;
    aff_waddr   = e_idx;
    aff_wdata   = cpu_q;
    hd_we       = 1'b0;
    hd_waddr    = lst_idx;
    hd_wdata    = cur_q;
    hd_raddr    = lst_idx;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      ST_INIT: begin
        // chain every entry to the next one, the last to the end marker, clear affinities
        nl_we     = 1'b1;
        nl_waddr  = init_q;
        nl_wdata  = (init_q == LAST_I) ? END_L : LW'(init_q) + LW'(1);
        aff_we    = 1'b1;
        aff_waddr = init_q;
        aff_wdata = 3'd0;
        init_d    = init_q + IW'(1);
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          mode_d    = in_i.mode;
          lst_d     = in_i.list_id;
          e_d       = in_i.entry;
          ch_d      = CHANNEL_BITS'(in_i.channel);
          cpu_d     = in_i.cpu;
          status_d  = STAT_OK;
          cnt_d     = '0;
          woken_d   = '0;
          at_head_d = 1'b1;
        end
      end
      ST_START: begin
        case (mode_q)
          MODE_POP: begin
            if (!lst_ok || head_empty) begin
              status_d = STAT_EMPTY;
            end else begin
              cur_d    = hd_rdata;
              nl_raddr = hd_rdata[IW-1:0];
            end
          end
          MODE_APPEND, MODE_REMOVE: begin
            cur_d    = hd_rdata;
            nl_raddr = e_idx;
            if (!lst_ok || !e_ok) status_d = STAT_NOTFOUND;
          end
          MODE_SLEEP: begin
            nl_raddr = e_idx;
            if (!e_ok) status_d = STAT_NOTFOUND;
          end
          MODE_WAKE: begin
            hd_raddr = SLEEP_H;
            cur_d    = hd_rdata;
          end
          MODE_COUNT: begin
            cur_d = hd_rdata;
          end
          MODE_SETAFF: begin
            if (!e_ok || !cpu_ok) status_d = STAT_NOTFOUND;
            else aff_we = 1'b1;
          end
          default: status_d = STAT_NOTFOUND;
        endcase
      end
      ST_POP2: begin
        hd_we    = 1'b1;
        hd_wdata = nl_rdata;
        nl_we    = 1'b1;
        nl_waddr = cur_idx;
        nl_wdata = NONE_L;
      end
      ST_CHECK: begin
        if (mode_q == MODE_SLEEP) hd_raddr = SLEEP_H;
        if (nl_rdata != NONE_L) begin
          status_d = STAT_LINKED;
        end else if (mode_q == MODE_SLEEP) begin
          wc_we    = 1'b1;
          nl_we    = 1'b1;
          nl_waddr = e_idx;
          nl_wdata = hd_rdata;
          hd_we    = 1'b1;
          hd_waddr = SLEEP_H;
          hd_wdata = LW'(e_q);
        end else begin
          nl_we    = 1'b1;
          nl_waddr = e_idx;
          nl_wdata = END_L;
          cur_d    = hd_rdata;
          if (head_empty) begin
            hd_we    = 1'b1;
            hd_wdata = LW'(e_q);
          end
        end
      end
      ST_WALK_RD: begin
        if ((cur_q >= END_L || cnt_q > N_C) && mode_q == MODE_REMOVE) begin
          status_d = STAT_NOTFOUND;
        end
      end
      ST_WALK: begin
        case (mode_q)
          MODE_APPEND: begin
            if (nl_rdata < END_L && cnt_q <= N_C) begin
              cur_d    = nl_rdata;
              cnt_d    = cnt_q + CW'(1);
              nl_raddr = nxt_idx;
            end else begin
              nl_we    = 1'b1;
              nl_wdata = LW'(e_q);
            end
          end
          MODE_COUNT: begin
            cur_d    = nl_rdata;
            cnt_d    = cnt_q + CW'(1);
            nl_raddr = nxt_idx;
          end
          MODE_REMOVE, MODE_WAKE: begin
            if ((mode_q == MODE_REMOVE && cur_q == LW'(e_q)) ||
                (mode_q == MODE_WAKE && wc_rdata == ch_q)) begin
              // splice the entry out of the list
              if (at_head_q) begin
                hd_we    = 1'b1;
                hd_waddr = (mode_q == MODE_WAKE) ? SLEEP_H : lst_idx;
                hd_wdata = nl_rdata;
              end else begin
                nl_we    = 1'b1;
                nl_waddr = prev_q;
                nl_wdata = nl_rdata;
              end
              nxt_d = nl_rdata;
              run_d = HW'(LIST_RUN0) + HW'(aff_cpu);
            end else begin
              prev_d    = cur_idx;
              at_head_d = 1'b0;
              cur_d     = nl_rdata;
              cnt_d     = cnt_q + CW'(1);
              nl_raddr  = nxt_idx;
              if (!cont && mode_q == MODE_REMOVE) status_d = STAT_NOTFOUND;
            end
          end
          default: ;
        endcase
      end
      ST_FIX: begin
        if (mode_q == MODE_WAKE) begin
          // push the woken entry onto its run list
          hd_raddr = run_q;
          nl_we    = 1'b1;
          nl_waddr = cur_idx;
          nl_wdata = hd_rdata;
          hd_we    = 1'b1;
          hd_waddr = run_q;
          hd_wdata = cur_q;
          woken_d  = (woken_q == TALLY_MAX) ? woken_q : woken_q + 7'd1;
          cur_d    = nxt_q;
          cnt_d    = cnt_q + CW'(1);
        end else begin
          nl_we    = 1'b1;
          nl_waddr = e_idx;
          nl_wdata = NONE_L;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_d        = 1'b1;
          out_d.status       = status_q;
          out_d.popped_entry = (mode_q == MODE_POP && status_q == STAT_OK) ? 6'(cur_q) : 6'd0;
          case (mode_q)
            MODE_COUNT: out_d.tally = (cnt_q > CW'(TALLY_MAX)) ? TALLY_MAX : 7'(cnt_q);
            MODE_WAKE:  out_d.tally = woken_q;
            default:    out_d.tally = 7'd0;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      init_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    lst_q     <= lst_d;
    e_q       <= e_d;
    ch_q      <= ch_d;
    cpu_q     <= cpu_d;
    cur_q     <= cur_d;
    nxt_q     <= nxt_d;
    prev_q    <= prev_d;
    at_head_q <= at_head_d;
    cnt_q     <= cnt_d;
    woken_q   <= woken_d;
    status_q  <= status_d;
    run_q     <= run_d;
    out_q     <= out_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
